>>> rtl/core/mexp_pkg.sv
// Shared constants and types for the modular exponentiation core.
`default_nettype none
package mexp_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(WORD_WIDTH);
  localparam int ADDR_W     = 4;
  localparam int APB_W      = 32;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP_BIT,
    ST_MUL_ADD,
    ST_MUL_DBL,
    ST_MUL_END,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation core: sequencer, registers and APB port.
// A zero modulus goes straight to finish; else the message is reduced mod n bit by bit,
// then per exponent bit (W = 32): acc *= base if the bit is 1, then base is squared mod n.
// One word is processed at a time; every step goes through one shared modular adder.
// A result waits in the output register; a new word is taken once the sequencer is idle.
// Reset (synchronous, rst_n low): sequencer idle, no result pending, modulus 1, exponents 0.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [WORD_WIDTH-1:0] in_message_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [WORD_WIDTH-1:0] out_result_value,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_W-1:0]      pwdata,
  output logic      [APB_W-1:0]      prdata,
  output logic                       pready
);

  state_t state_r, state_nxt;

  logic [WORD_WIDTH-1:0] modulus_r, public_exp_r, private_exp_r;
  logic [WORD_WIDTH-1:0] base_r, base_nxt;
  logic [WORD_WIDTH-1:0] acc_r, acc_nxt;
  logic [WORD_WIDTH-1:0] exp_r, exp_nxt;
  logic [WORD_WIDTH-1:0] ma_r, ma_nxt;
  logic [WORD_WIDTH-1:0] mb_r, mb_nxt;
  logic [WORD_WIDTH-1:0] mp_r, mp_nxt;
  logic [WORD_WIDTH-1:0] result_r, result_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      ecnt_r, ecnt_nxt;
  logic                  sq_r, sq_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [WORD_WIDTH-1:0] add_x, add_y, add_sum;
  logic                  add_cin;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  mexp_modadd u_modadd (
    .x   (add_x),
    .y   (add_y),
    .cin (add_cin),
    .n   (modulus_r),
    .sum (add_sum)
  );

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_MODULUS:     prdata = APB_W'(modulus_r);
      REG_PUBLIC_EXP:  prdata = APB_W'(public_exp_r);
      REG_PRIVATE_EXP: prdata = APB_W'(private_exp_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r     <= WORD_WIDTH'(1);
      public_exp_r  <= '0;
      private_exp_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODULUS:     modulus_r     <= pwdata[WORD_WIDTH-1:0];
        REG_PUBLIC_EXP:  public_exp_r  <= pwdata[WORD_WIDTH-1:0];
        REG_PRIVATE_EXP: private_exp_r <= pwdata[WORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    mp_nxt        = mp_r;
    result_nxt    = result_r;
    cnt_nxt       = cnt_r;
    ecnt_nxt      = ecnt_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r && !out_ready;
    add_x         = ma_r;
    add_y         = ma_r;
    add_cin       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          base_nxt = '0;
          mb_nxt   = in_message_value;
          exp_nxt  = in_op ? private_exp_r : public_exp_r;
          acc_nxt  = (modulus_r == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
          cnt_nxt  = '0;
          ecnt_nxt = '0;
          if (modulus_r == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        add_x    = base_r;
        add_y    = base_r;
        add_cin  = mb_r[WORD_WIDTH-1];
        base_nxt = add_sum;
        mb_nxt   = {mb_r[WORD_WIDTH-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EXP_BIT;
        end
      end
      ST_EXP_BIT: begin
        mp_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MUL_ADD;
        if (exp_r[0]) begin
          ma_nxt = acc_r;
          mb_nxt = base_r;
          sq_nxt = 1'b0;
        end else begin
          ma_nxt = base_r;
          mb_nxt = base_r;
          sq_nxt = 1'b1;
        end
      end
      ST_MUL_ADD: begin
        add_x = mp_r;
        add_y = ma_r;
        if (mb_r[0]) begin
          mp_nxt = add_sum;
        end
        state_nxt = ST_MUL_DBL;
      end
      ST_MUL_DBL: begin
        ma_nxt  = add_sum;
        mb_nxt  = {1'b0, mb_r[WORD_WIDTH-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == CNT_LAST) ? ST_MUL_END : ST_MUL_ADD;
      end
      ST_MUL_END: begin
        if (!sq_r) begin
          acc_nxt   = mp_r;
          ma_nxt    = base_r;
          mb_nxt    = base_r;
          mp_nxt    = '0;
          cnt_nxt   = '0;
          sq_nxt    = 1'b1;
          state_nxt = ST_MUL_ADD;
        end else begin
          base_nxt  = mp_r;
          exp_nxt   = {1'b0, exp_r[WORD_WIDTH-1:1]};
          ecnt_nxt  = ecnt_r + 1'b1;
          state_nxt = (ecnt_r == CNT_LAST) ? ST_FINISH : ST_EXP_BIT;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          result_nxt    = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    acc_r    <= acc_nxt;
    exp_r    <= exp_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    mp_r     <= mp_nxt;
    result_r <= result_nxt;
    cnt_r    <= cnt_nxt;
    ecnt_r   <= ecnt_nxt;
    sq_r     <= sq_nxt;
  end

  // operands stay reduced while multiplying
  a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_ADD || state_r == ST_MUL_DBL) |->
      (ma_r < modulus_r && mp_r < modulus_r && base_r < modulus_r))
    else $error("multiplier operand not reduced");

  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && modulus_r == '0) |=> (state_r == ST_FINISH && acc_r == '0))
    else $error("zero modulus path not taken");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished word not presented");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(result_r)))
    else $error("pending result lost");

endmodule
`default_nettype wire

>>> rtl/core/mexp_modadd.sv
// Shared modular adder: (x + y + cin) mod n for x, y below n.
`default_nettype none
module mexp_modadd
  import mexp_pkg::*;
(
  input  wire logic [WORD_WIDTH-1:0] x,
  input  wire logic [WORD_WIDTH-1:0] y,
  input  wire logic                  cin,
  input  wire logic [WORD_WIDTH-1:0] n,
  output logic      [WORD_WIDTH-1:0] sum
);

  logic [WORD_WIDTH:0] raw;
  logic [WORD_WIDTH:0] diff;

  always_comb begin
    raw  = {1'b0, x} + {1'b0, y} + {{WORD_WIDTH{1'b0}}, cin};
    diff = raw - {1'b0, n};
    if (raw >= {1'b0, n}) begin
      sum = diff[WORD_WIDTH-1:0];
    end else begin
      sum = raw[WORD_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire
